// ===== rtl/gnpm_pkg.sv =====
// Shared types, constants and codes for the greedy nearest-point matcher.
package gnpm_pkg;

   localparam int MAX_POINTS_DEF = 1024;
   localparam int COORD_BITS_DEF = 16;

   localparam int IN_COORD_W = 16;
   localparam int PT_INDEX_W = 10;
   localparam int TAG_W      = 16;
   localparam int DIST_W     = 34;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   typedef enum logic [0:0] {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } ctrl_state_type;

   typedef struct packed {
      logic clear_step;
      logic load_write;
      logic query_start;
      logic scan_issue;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_addr;
      logic pipe_busy;
   } dp_status_type;

endpackage

// ===== rtl/greedy_nearest_point_matcher.sv =====
// Top level of the greedy nearest-point matcher: controller, datapath and checks.
// A load transfer (op 0) writes one reference point and marks it available; the
// next transfer can follow straight away. A query transfer (op 1) reads every
// slot of the point memory once, one slot per cycle through a four-stage
// distance pipeline, and its result is written to the result register. The
// nearest available point wins, the lower slot on a tie, and it is marked used
// only when its squared distance does not exceed the cutoff. After reset the
// block clears the available marks, one slot per cycle, before it takes its
// first transfer; cutoff writes are taken at any time. The cutoff should only
// be written while no query is in progress.
module greedy_nearest_point_matcher
   import gnpm_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [DIST_W-1:0]            csr_cutoff_squared,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic [PT_INDEX_W-1:0]        req_point_index,
   input  logic signed [IN_COORD_W-1:0] req_coord_x,
   input  logic signed [IN_COORD_W-1:0] req_coord_y,
   input  logic signed [IN_COORD_W-1:0] req_coord_z,
   input  logic [TAG_W-1:0]             req_query_tag,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [TAG_W-1:0]             rsp_result_tag,
   output logic                         rsp_found,
   output logic [PT_INDEX_W-1:0]        rsp_match_index,
   output logic [DIST_W-1:0]            rsp_distance_squared
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   gnpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   gnpm_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .cfg_write            (csr_valid && csr_ready),
      .cfg_cutoff           (csr_cutoff_squared),
      .req_point_index      (req_point_index),
      .req_coord_x          (req_coord_x),
      .req_coord_y          (req_coord_y),
      .req_coord_z          (req_coord_z),
      .req_query_tag        (req_query_tag),
      .rsp_result_tag       (rsp_result_tag),
      .rsp_found            (rsp_found),
      .rsp_match_index      (rsp_match_index),
      .rsp_distance_squared (rsp_distance_squared)
   );

   // A new transfer is never taken while distance calculations are still in flight.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !status.pipe_busy)
      else $error("transfer accepted while the distance pipeline is busy");

   // A result appears only after the controller has completed a query.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.finish))
      else $error("result appeared without a completed query");

   // A pending result is never overwritten before its transfer.
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || !rsp_stall))
      else $error("pending result overwritten");

   // Loads and the clearing pass never overlap the scan.
   assert property (@(posedge clock) disable iff (reset)
      cmd.scan_issue |-> !(cmd.load_write || cmd.clear_step || cmd.finish))
      else $error("memory write issued during a scan");

endmodule

// ===== rtl/gnpm_ctrl.sv =====
// Controller state machine: clearing pass, loads, query scan sequencing and result hand-off.
module gnpm_ctrl
   import gnpm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_op,
   output logic          req_stall,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.last_addr) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_op == OP_QUERY) begin
                  cmd.query_start = 1'b1;
                  state_in        = ST_SCAN;
               end else begin
                  cmd.load_write = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/gnpm_datapath.sv =====
// Datapath: point and availability memories, distance pipeline, best-match tracking, result register.
module gnpm_datapath
   import gnpm_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ctrl_cmd_type                 cmd,
   output dp_status_type                status,
   input  logic                         cfg_write,
   input  logic [DIST_W-1:0]            cfg_cutoff,
   input  logic [PT_INDEX_W-1:0]        req_point_index,
   input  logic signed [IN_COORD_W-1:0] req_coord_x,
   input  logic signed [IN_COORD_W-1:0] req_coord_y,
   input  logic signed [IN_COORD_W-1:0] req_coord_z,
   input  logic [TAG_W-1:0]             req_query_tag,
   output logic [TAG_W-1:0]             rsp_result_tag,
   output logic                         rsp_found,
   output logic [PT_INDEX_W-1:0]        rsp_match_index,
   output logic [DIST_W-1:0]            rsp_distance_squared
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CW    = COORD_BITS;
   localparam int PW    = 3 * CW;
   localparam int SW    = 2 * CW;
   localparam int SUM_W = SW + 2;
   localparam int DW    = (SUM_W > DIST_W) ? SUM_W : DIST_W;

   logic [PW-1:0] store_mem [MAX_POINTS];
   logic          avail_mem [MAX_POINTS];

   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic [DIST_W-1:0] cutoff_ff;
   logic              last_addr;

   logic signed [CW-1:0] in_x, in_y, in_z;
   logic signed [CW-1:0] q_x_ff, q_y_ff, q_z_ff;
   logic [TAG_W-1:0]     tag_ff;

   logic              load_ok;
   logic [IDX_W-1:0]  load_addr;
   logic              av_we;
   logic [IDX_W-1:0]  av_addr;
   logic              av_data;

   logic              s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic              s1_av_ff, s2_av_ff, s3_av_ff, s4_av_ff;
   logic [IDX_W-1:0]  s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff;
   logic [PW-1:0]     s1_pt_ff;
   logic [CW:0]       dx, dy, dz;
   logic [CW-1:0]     ax_in, ay_in, az_in;
   logic [CW-1:0]     s2_ax_ff, s2_ay_ff, s2_az_ff;
   logic [SW-1:0]     sqx_in, sqy_in, sqz_in;
   logic [SW-1:0]     s3_sqx_ff, s3_sqy_ff, s3_sqz_ff;
   logic [DW-1:0]     sum_in;
   logic [DW-1:0]     s4_sum_ff;

   logic              have_ff, have_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [DW-1:0]     best_d_ff, best_d_in;
   logic              found;

   assign in_x = CW'(req_coord_x);
   assign in_y = CW'(req_coord_y);
   assign in_z = CW'(req_coord_z);

   assign last_addr = (cnt_ff == IDX_W'(MAX_POINTS - 1));
   assign load_ok   = (32'(req_point_index) < 32'(MAX_POINTS));
   assign load_addr = IDX_W'(req_point_index);

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.query_start) begin
         cnt_in = '0;
      end else if (cmd.clear_step || cmd.scan_issue) begin
         cnt_in = last_addr ? '0 : cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         cutoff_ff <= DIST_MAX;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         s1_vld_ff <= cmd.scan_issue;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         if (cfg_write) begin
            cutoff_ff <= cfg_cutoff;
         end
      end
   end

   always_comb begin
      av_we   = 1'b0;
      av_addr = cnt_ff;
      av_data = 1'b0;
      priority if (cmd.clear_step) begin
         av_we = 1'b1;
      end else if (cmd.load_write) begin
         av_we   = load_ok;
         av_addr = load_addr;
         av_data = 1'b1;
      end else if (cmd.finish) begin
         av_we   = found;
         av_addr = best_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_write && load_ok) begin
         store_mem[load_addr] <= {in_z, in_y, in_x};
      end
      if (av_we) begin
         avail_mem[av_addr] <= av_data;
      end
      s1_pt_ff <= store_mem[cnt_ff];
      s1_av_ff <= avail_mem[cnt_ff];
   end

   always_comb begin
      dx = (CW+1)'(q_x_ff) - (CW+1)'($signed(s1_pt_ff[CW-1:0]));
      dy = (CW+1)'(q_y_ff) - (CW+1)'($signed(s1_pt_ff[2*CW-1:CW]));
      dz = (CW+1)'(q_z_ff) - (CW+1)'($signed(s1_pt_ff[3*CW-1:2*CW]));
      ax_in = dx[CW] ? CW'(-dx) : dx[CW-1:0];
      ay_in = dy[CW] ? CW'(-dy) : dy[CW-1:0];
      az_in = dz[CW] ? CW'(-dz) : dz[CW-1:0];
      sqx_in = SW'(s2_ax_ff) * SW'(s2_ax_ff);
      sqy_in = SW'(s2_ay_ff) * SW'(s2_ay_ff);
      sqz_in = SW'(s2_az_ff) * SW'(s2_az_ff);
      sum_in = DW'(s3_sqx_ff) + DW'(s3_sqy_ff) + DW'(s3_sqz_ff);
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= cnt_ff;
      s2_ax_ff  <= ax_in;
      s2_ay_ff  <= ay_in;
      s2_az_ff  <= az_in;
      s2_av_ff  <= s1_av_ff;
      s2_idx_ff <= s1_idx_ff;
      s3_sqx_ff <= sqx_in;
      s3_sqy_ff <= sqy_in;
      s3_sqz_ff <= sqz_in;
      s3_av_ff  <= s2_av_ff;
      s3_idx_ff <= s2_idx_ff;
      s4_sum_ff <= sum_in;
      s4_av_ff  <= s3_av_ff;
      s4_idx_ff <= s3_idx_ff;
   end

   always_comb begin
      have_in     = have_ff;
      best_idx_in = best_idx_ff;
      best_d_in   = best_d_ff;
      if (cmd.query_start) begin
         have_in     = 1'b0;
         best_idx_in = '0;
         best_d_in   = '0;
      end else if (s4_vld_ff && s4_av_ff && (!have_ff || s4_sum_ff < best_d_ff)) begin
         have_in     = 1'b1;
         best_idx_in = s4_idx_ff;
         best_d_in   = s4_sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
      best_idx_ff <= best_idx_in;
      best_d_ff   <= best_d_in;
      if (cmd.query_start) begin
         q_x_ff <= in_x;
         q_y_ff <= in_y;
         q_z_ff <= in_z;
         tag_ff <= req_query_tag;
      end
   end

   assign found = have_ff && (best_d_ff <= DW'(cutoff_ff));

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_result_tag       <= tag_ff;
         rsp_found            <= found;
         rsp_match_index      <= PT_INDEX_W'(best_idx_ff);
         rsp_distance_squared <= (best_d_ff > DW'(DIST_MAX)) ? DIST_MAX
                                                              : best_d_ff[DIST_W-1:0];
      end
   end

   assign status.last_addr = last_addr;
   assign status.pipe_busy = s1_vld_ff | s2_vld_ff | s3_vld_ff | s4_vld_ff;

endmodule

// ===== verif/greedy_nearest_point_matcher_tb.sv =====
// Self-checking testbench for the greedy nearest-point matcher, with directed and random traffic.
module greedy_nearest_point_matcher_tb
   import gnpm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SLOTS     = MAX_POINTS_DEF;
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 16;
   localparam int QUIET_LIMIT   = 8000;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 93;
   localparam int REPORT_CAP    = 50;

   typedef enum logic [0:0] {
      ROW_ITEM,
      ROW_CUTOFF
   } plan_kind_type;

   typedef struct {
      op_type                       op;
      logic [PT_INDEX_W-1:0]        index;
      logic signed [IN_COORD_W-1:0] x;
      logic signed [IN_COORD_W-1:0] y;
      logic signed [IN_COORD_W-1:0] z;
      logic [TAG_W-1:0]             tag;
   } point_req_type;

   typedef struct packed {
      logic [TAG_W-1:0]      tag;
      logic                  found;
      logic [PT_INDEX_W-1:0] index;
      logic [DIST_W-1:0]     dist_sq;
   } match_type;

   typedef struct {
      plan_kind_type     kind;
      point_req_type     item;
      logic [DIST_W-1:0] cutoff;
      bit                typed;
      match_type         want;
   } plan_row_type;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [DIST_W-1:0]            csr_cutoff_squared = '0;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_op = 1'b0;
   logic [PT_INDEX_W-1:0]        req_point_index = '0;
   logic signed [IN_COORD_W-1:0] req_coord_x = '0;
   logic signed [IN_COORD_W-1:0] req_coord_y = '0;
   logic signed [IN_COORD_W-1:0] req_coord_z = '0;
   logic [TAG_W-1:0]             req_query_tag = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [TAG_W-1:0]             rsp_result_tag;
   logic                         rsp_found;
   logic [PT_INDEX_W-1:0]        rsp_match_index;
   logic [DIST_W-1:0]            rsp_distance_squared;

   logic signed [IN_COORD_W-1:0] slot_x [MAX_SLOTS];
   logic signed [IN_COORD_W-1:0] slot_y [MAX_SLOTS];
   logic signed [IN_COORD_W-1:0] slot_z [MAX_SLOTS];
   bit                           slot_available [MAX_SLOTS];
   logic [DIST_W-1:0]            cutoff_now = DIST_MAX;

   match_type    awaited_matches [$];
   plan_row_type directed_plan [$];
   int           centre_x [4];
   int           centre_y [4];
   int           centre_z [4];
   int           mismatch_count = 0;
   int           quiet_cycles = 0;
   bit           steady_traffic = 1'b0;

   greedy_nearest_point_matcher u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_cutoff_squared   (csr_cutoff_squared),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_op               (req_op),
      .req_point_index      (req_point_index),
      .req_coord_x          (req_coord_x),
      .req_coord_y          (req_coord_y),
      .req_coord_z          (req_coord_z),
      .req_query_tag        (req_query_tag),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_tag       (rsp_result_tag),
      .rsp_found            (rsp_found),
      .rsp_match_index      (rsp_match_index),
      .rsp_distance_squared (rsp_distance_squared)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_traffic || roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 120);
   endfunction

   // Loads update the point store; a query scans every slot and returns one result.
   function automatic bit predict_matcher(input point_req_type it, output match_type res);
      longint dx, dy, dz, d, best_d;
      int best;
      bit have;
      have = 1'b0;
      best = 0;
      best_d = 0;
      res = '0;
      if (it.op == OP_LOAD) begin
         if (int'(it.index) < MAX_SLOTS) begin
            slot_x[it.index] = it.x;
            slot_y[it.index] = it.y;
            slot_z[it.index] = it.z;
            slot_available[it.index] = 1'b1;
         end
         return 1'b0;
      end
      for (int k = 0; k < MAX_SLOTS; k++) begin
         if (!slot_available[k]) continue;
         dx = longint'(it.x) - longint'(slot_x[k]);
         dy = longint'(it.y) - longint'(slot_y[k]);
         dz = longint'(it.z) - longint'(slot_z[k]);
         d = dx * dx + dy * dy + dz * dz;
         if (!have || d < best_d) begin
            have = 1'b1;
            best = k;
            best_d = d;
         end
      end
      res.tag = it.tag;
      if (have) begin
         res.index = PT_INDEX_W'(best);
         res.dist_sq = (best_d > longint'(DIST_MAX)) ? DIST_MAX : DIST_W'(best_d);
         if (best_d <= longint'(cutoff_now)) begin
            res.found = 1'b1;
            slot_available[best] = 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic point_req_type make_point(input op_type op, input int slot, input int x,
                                                input int y, input int z, input int tag);
      point_req_type it;
      it.op = op;
      it.index = PT_INDEX_W'(slot);
      it.x = IN_COORD_W'(x);
      it.y = IN_COORD_W'(y);
      it.z = IN_COORD_W'(z);
      it.tag = TAG_W'(tag);
      return it;
   endfunction

   function automatic void plan_load(input int slot, input int x, input int y, input int z);
      plan_row_type row;
      row.kind = ROW_ITEM;
      row.item = make_point(OP_LOAD, slot, x, y, z, slot * 5);
      row.cutoff = '0;
      row.typed = 1'b0;
      row.want = '0;
      directed_plan = {directed_plan, row};
   endfunction

   function automatic void plan_query(input int x, input int y, input int z, input int tag,
                                      input bit typed, input bit found, input int slot,
                                      input logic [DIST_W-1:0] want_dist);
      plan_row_type row;
      row.kind = ROW_ITEM;
      row.item = make_point(OP_QUERY, tag * 7, x, y, z, tag);
      row.cutoff = '0;
      row.typed = typed;
      row.want.tag = TAG_W'(tag);
      row.want.found = found;
      row.want.index = PT_INDEX_W'(slot);
      row.want.dist_sq = want_dist;
      directed_plan = {directed_plan, row};
   endfunction

   function automatic void plan_cutoff(input logic [DIST_W-1:0] value);
      plan_row_type row;
      row.kind = ROW_CUTOFF;
      row.item = make_point(OP_LOAD, 0, 0, 0, 0, 0);
      row.cutoff = value;
      row.typed = 1'b0;
      row.want = '0;
      directed_plan = {directed_plan, row};
   endfunction

   function automatic point_req_type random_point();
      point_req_type it;
      int c, spread;
      it.tag = TAG_W'($urandom);
      it.index = PT_INDEX_W'($urandom);
      if ($urandom_range(0, 99) < 12) begin
         it.op = op_type'($urandom_range(0, 1));
         it.x = IN_COORD_W'($urandom);
         it.y = IN_COORD_W'($urandom);
         it.z = IN_COORD_W'($urandom);
         return it;
      end
      c = $urandom_range(0, 3);
      spread = ($urandom_range(0, 9) == 0) ? 1 : 40;
      it.op = ($urandom_range(0, 99) < 35) ? OP_QUERY : OP_LOAD;
      if (it.op == OP_LOAD && $urandom_range(0, 3) != 0) begin
         it.index = PT_INDEX_W'($urandom_range(0, 47));
      end
      it.x = IN_COORD_W'(centre_x[c] + int'($urandom_range(0, 2 * spread)) - spread);
      it.y = IN_COORD_W'(centre_y[c] + int'($urandom_range(0, 2 * spread)) - spread);
      it.z = IN_COORD_W'(centre_z[c] + int'($urandom_range(0, 2 * spread)) - spread);
      return it;
   endfunction

   task automatic issue_item(input point_req_type it, input bit typed, input match_type want);
      int gap;
      match_type got;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= it.op;
      req_point_index <= it.index;
      req_coord_x <= it.x;
      req_coord_y <= it.y;
      req_coord_z <= it.z;
      req_query_tag <= it.tag;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      if (predict_matcher(it, got)) begin
         if (typed) got = want;
         awaited_matches = {awaited_matches, got};
      end
   endtask

   task automatic drain(input int settle);
      req_valid <= 1'b0;
      while (awaited_matches.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_cutoff(input logic [DIST_W-1:0] value);
      drain(SETTLE_CYCLES);
      csr_valid <= 1'b1;
      csr_cutoff_squared <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      cutoff_now = value;
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < REPORT_CAP) begin
         $display("%0t: %s is %0h, %0h was due", $time, field, got, want);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      match_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (awaited_matches.size() == 0) begin
            report_mismatch("unexpected result with tag", 64'(rsp_result_tag), 64'd0);
         end else begin
            want = awaited_matches.pop_front();
            if (rsp_result_tag !== want.tag)
               report_mismatch("result_tag", 64'(rsp_result_tag), 64'(want.tag));
            if (rsp_found !== want.found)
               report_mismatch("found", 64'(rsp_found), 64'(want.found));
            if (rsp_match_index !== want.index)
               report_mismatch("match_index", 64'(rsp_match_index), 64'(want.index));
            if (rsp_distance_squared !== want.dist_sq)
               report_mismatch("distance_squared", 64'(rsp_distance_squared),
                               64'(want.dist_sq));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)
          || (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int hold;
      @(posedge clock);
      forever begin
         hold = pick_gap();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin
      plan_row_type row;
      logic [DIST_W-1:0] phase_cutoff;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // The first rows run with the cutoff still at its reset value.
      plan_query(0, 0, 0, 16'h0001, 1'b1, 1'b0, 0, '0);
      plan_load(0, 32767, 32767, 32767);
      plan_load(1023, -32768, -32768, -32768);
      plan_query(-32768, -32768, -32768, 16'hFFFF, 1'b1, 1'b1, 1023, '0);
      plan_query(-32768, -32768, -32768, 16'h0000, 1'b1, 1'b1, 0, 34'd12884508675);
      plan_query(0, 0, 0, 3, 1'b1, 1'b0, 0, '0);
      plan_load(5, 10, 0, 0);
      plan_load(3, -10, 0, 0);
      plan_query(0, 0, 0, 4, 1'b1, 1'b1, 3, 34'd100);
      plan_query(0, 0, 0, 5, 1'b1, 1'b1, 5, 34'd100);
      plan_load(5, 1, 2, 3);
      plan_query(1, 2, 3, 6, 1'b1, 1'b1, 5, '0);
      plan_load(7, 100, -200, 300);
      plan_load(7, -100, 200, -300);
      plan_query(-100, 200, -300, 7, 1'b1, 1'b1, 7, '0);
      plan_cutoff(34'd99);
      plan_load(2, 0, 0, 10);
      plan_query(0, 0, 0, 8, 1'b1, 1'b0, 2, 34'd100);
      plan_cutoff(34'd100);
      plan_query(0, 0, 0, 9, 1'b1, 1'b1, 2, 34'd100);
      plan_cutoff('0);
      plan_load(9, 5, 5, 5);
      plan_load(11, -7, 4, 12);
      plan_query(5, 5, 6, 10, 1'b1, 1'b0, 9, 34'd1);
      plan_query(5, 5, 5, 11, 1'b1, 1'b1, 9, '0);
      plan_query(-3, 8, 9, 12, 1'b0, 1'b0, 0, '0);
      plan_query(-20000, 15000, 3, 16'hA5A5, 1'b0, 1'b0, 0, '0);

      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.kind == ROW_CUTOFF) begin
            write_cutoff(row.cutoff);
         end else begin
            issue_item(row.item, row.typed, row.want);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         for (int c = 0; c < 4; c++) begin
            centre_x[c] = int'($urandom_range(0, 60000)) - 30000;
            centre_y[c] = int'($urandom_range(0, 60000)) - 30000;
            centre_z[c] = int'($urandom_range(0, 60000)) - 30000;
         end
         steady_traffic = (phase == 3);
         case (phase)
            0: phase_cutoff = DIST_MAX;
            1: phase_cutoff = '0;
            2: phase_cutoff = DIST_W'($urandom_range(0, 3000));
            3: phase_cutoff = DIST_W'($urandom_range(3000, 20000));
            4: phase_cutoff = {2'($urandom_range(0, 3)), 32'($urandom)};
            default: phase_cutoff = DIST_MAX;
         endcase
         write_cutoff(phase_cutoff);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 199) == 0) drain(SETTLE_CYCLES);
            issue_item(random_point(), 1'b0, '0);
         end
      end

      drain(MAX_SLOTS + SETTLE_CYCLES);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
